>>> hdl/iuc_pkg.sv
// ---------------------------------------------------------------------------
// iuc_pkg
// Shared types for the interval union coverage block.
// ---------------------------------------------------------------------------
package iuc_pkg;

    typedef struct packed {
        logic [19:0] start_pos;
        logic [19:0] end_pos;
        logic        is_last;
    } iuc_in_t;

    typedef struct packed {
        logic [20:0] covered_bases;
        logic [8:0]  merged_count;
        logic        overflow;
    } iuc_out_t;

    localparam int COVERED_W = 21;
    localparam int MERGED_W  = 9;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_MERGE,
        ST_EMIT
    } iuc_state_t;

endpackage

>>> hdl/iuc_ram.sv
// ---------------------------------------------------------------------------
// iuc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module iuc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> hdl/iuc_front.sv
// ---------------------------------------------------------------------------
// iuc_front
// Accepts intervals, orders each pair and pushes them into a two-entry queue.
// ---------------------------------------------------------------------------
module iuc_front #(
    parameter int COORD_BITS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  iuc_pkg::iuc_in_t   in_data,
    output logic               q_valid,
    input  logic               q_pop,
    output logic [COORD_BITS-1:0] q_start,
    output logic [COORD_BITS-1:0] q_end,
    output logic               q_last
);
    import iuc_pkg::*;

    localparam int EW = 2 * COORD_BITS + 1;

    logic [EW-1:0] slot_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rp_reg, rp_next, wp_reg, wp_next;
    logic [COORD_BITS-1:0] s_in, e_in, lo, hi;
    logic          push;

    // mask coordinates and swap a reversed pair
    assign s_in = COORD_BITS'(in_data.start_pos);
    assign e_in = COORD_BITS'(in_data.end_pos);
    assign lo   = (e_in < s_in) ? e_in : s_in;
    assign hi   = (e_in < s_in) ? s_in : e_in;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign {q_start, q_end, q_last} = slot_reg[rp_reg];

    // queue pointers
    always_comb
    begin
        cnt_next = cnt_reg;
        rp_next  = rp_reg;
        wp_next  = wp_reg;
        if (push)
        begin
            wp_next = !wp_reg;
        end
        if (q_pop && q_valid)
        begin
            rp_next = !rp_reg;
        end
        if (push && !(q_pop && q_valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop && q_valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rp_reg  <= rp_next;
            wp_reg  <= wp_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= {lo, hi, in_data.is_last};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> in_stall)
        else $error("full queue not stalling");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !q_valid)
        else $error("empty queue shows valid");
endmodule

>>> hdl/iuc_back.sv
// ---------------------------------------------------------------------------
// iuc_back
// Insertion-sorts intervals into RAM, then walks them and merges the union.
// ---------------------------------------------------------------------------
module iuc_back #(
    parameter int COORD_BITS    = 20,
    parameter int MAX_INTERVALS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [COORD_BITS-1:0] q_start,
    input  logic [COORD_BITS-1:0] q_end,
    input  logic                  q_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output iuc_pkg::iuc_out_t     out_data
);
    import iuc_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int SW = COORD_BITS + 2;
    localparam int EW = 2 * COORD_BITS;

    iuc_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          phase_reg, phase_next;
    logic          last_reg, last_next;
    logic [COORD_BITS-1:0] ks_reg, ks_next, ke_reg, ke_next;
    logic [COORD_BITS-1:0] cs_reg, cs_next, ce_reg, ce_next;
    logic [SW-1:0] cov_reg, cov_next;
    logic [CW:0]   mrg_reg, mrg_next;
    iuc_out_t      res_reg, res_next;
    logic          ov_reg, ov_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [COORD_BITS-1:0] rs, re;
    logic [SW-1:0] cov_fin;

    iuc_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );
    assign {rs, re} = rd_data;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    if (count_reg == CW'(MAX_INTERVALS))
                        state_next = q_last ? ST_MERGE : ST_LOAD;
                    else if (count_reg != '0)
                        state_next = ST_SORT;
                    else
                        state_next = q_last ? ST_MERGE : ST_LOAD;
                end
            end
            ST_SORT:
            begin
                if (phase_reg && (idx_reg == '0 || !(rs > ks_reg)))
                    state_next = last_reg ? ST_MERGE : ST_LOAD;
            end
            ST_MERGE:
            begin
                if (phase_reg && idx_reg == count_reg && !ov_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // closing span of the merge walk
    assign cov_fin = (mrg_reg != '0)
        ? cov_reg + SW'(ce_reg - cs_reg) + SW'(1) : cov_reg;

    // datapath and outputs
    always_comb
    begin
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = {ks_reg, ke_reg};
        rd_addr    = '0;
        count_next = count_reg;
        drop_next  = drop_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        ks_next    = ks_reg;
        ke_next    = ke_reg;
        cs_next    = cs_reg;
        ce_next    = ce_reg;
        cov_next   = cov_reg;
        mrg_next   = mrg_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && out_stall;
        unique case (state_reg)
            ST_LOAD:
            begin
                q_pop = q_valid;
                if (q_pop)
                begin
                    last_next  = q_last;
                    ks_next    = q_start;
                    ke_next    = q_end;
                    phase_next = 1'b0;
                    idx_next   = count_reg;
                    cov_next   = '0;
                    mrg_next   = '0;
                    if (count_reg == CW'(MAX_INTERVALS))
                    begin
                        drop_next = 1'b1;
                        idx_next  = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = {q_start, q_end};
                        count_next = CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_SORT:
            begin
                // phase 0 reads slot idx-1, phase 1 shifts or places the key
                if (!phase_reg)
                begin
                    rd_addr    = AW'(idx_reg - CW'(1));
                    phase_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (idx_reg != '0 && rs > ks_reg)
                    begin
                        wr_data    = rd_data;
                        idx_next   = idx_reg - CW'(1);
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        idx_next   = '0;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_MERGE:
            begin
                if (!phase_reg)
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    phase_next = 1'b1;
                    if (idx_reg == count_reg)
                        phase_next = 1'b1;
                end
                else if (idx_reg == count_reg)
                begin
                    // hold the walk while an earlier result still waits
                    if (!ov_reg)
                    begin
                        res_next.covered_bases = (cov_fin > SW'((1 << COVERED_W) - 1))
                            ? COVERED_W'((1 << COVERED_W) - 1) : COVERED_W'(cov_fin);
                        res_next.merged_count = (mrg_reg > (CW+1)'((1 << MERGED_W) - 1))
                            ? MERGED_W'((1 << MERGED_W) - 1) : MERGED_W'(mrg_reg);
                        res_next.overflow = drop_reg;
                        phase_next = 1'b0;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    idx_next   = idx_reg + CW'(1);
                    if (mrg_reg != '0 && rs <= ce_reg)
                    begin
                        if (re > ce_reg)
                            ce_next = re;
                    end
                    else
                    begin
                        if (mrg_reg != '0)
                            cov_next = cov_fin;
                        cs_next  = rs;
                        ce_next  = re;
                        mrg_next = mrg_reg + (CW+1)'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                ov_next    = 1'b1;
                count_next = '0;
                drop_next  = 1'b0;
            end
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        ks_reg   <= ks_next;
        ke_reg   <= ke_next;
        cs_reg   <= cs_next;
        ce_reg   <= ce_next;
        cov_reg  <= cov_next;
        mrg_reg  <= mrg_next;
        res_reg  <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("stored count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> (count_reg == '0 && !drop_reg))
        else $error("set not cleared after result");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_LOAD))
        else $error("pop outside load state");
endmodule

>>> hdl/interval_union_coverage_top.sv
// A transaction is written into the front queue when accepted and popped by the
// back end in its load state. Into an empty store it is written on the pop, into
// a full one dropped; otherwise the insertion sort reads and shifts each stored
// entry it moves past, then places it. The final one adds a merge walk over the
// stored intervals, then registers the result; the walk end holds while an older
// result waits. No pop during sort or merge; reset clears the set, not the RAM.
// ---------------------------------------------------------------------------
// interval_union_coverage_top
// Union length and merged count of one set of inclusive intervals.
// ---------------------------------------------------------------------------
module interval_union_coverage_top #(
    parameter int MAX_INTERVALS = 256,
    parameter int COORD_BITS    = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  iuc_pkg::iuc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output iuc_pkg::iuc_out_t out_data
);
    import iuc_pkg::*;

    logic                  q_valid, q_pop, q_last;
    logic [COORD_BITS-1:0] q_start, q_end;

    // front: accept and order each pair
    iuc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop),
        .q_start(q_start), .q_end(q_end), .q_last(q_last)
    );

    // back: sort, merge and report
    iuc_back #(.COORD_BITS(COORD_BITS), .MAX_INTERVALS(MAX_INTERVALS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_start(q_start), .q_end(q_end), .q_last(q_last),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for interval_union_coverage_top. Sets of intervals are sent as
// transactions. A behavioral model sorts and merges each set and queues the
// expected coverage result, which the monitor compares field by field.
// ---------------------------------------------------------------------------
module tb_top;
    import iuc_pkg::*;

    localparam int CAPACITY   = 256;
    localparam int CYCLE_CAP  = 3000000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    iuc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    iuc_out_t out_data;

    interval_union_coverage_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // pending intervals and expected coverage results
    iuc_in_t  interval_queue[$];
    iuc_out_t coverage_queue[$];

    // model copy of the interval store
    logic [19:0] set_lo[CAPACITY];
    logic [19:0] set_hi[CAPACITY];
    int          set_size;
    logic        set_dropped;

    int  mismatches;
    bit  stim_done;
    bit  quiet_phase;
    bit  in_done;
    int  in_gap;
    int  out_gap;
    int  cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // append one pending interval
    function automatic void add_interval(iuc_in_t t);
        interval_queue = {interval_queue, t};
    endfunction

    // store one interval and compute the union result on a closing one
    function automatic void model_interval(iuc_in_t t);
        logic [19:0] lo, hi, ks, ke, cur_lo, cur_hi;
        int          merged, j;
        longint      covered;
        iuc_out_t    res;
        lo = t.start_pos;
        hi = t.end_pos;
        if (hi < lo)
        begin
            lo = t.end_pos;
            hi = t.start_pos;
        end
        if (set_size < CAPACITY)
        begin
            set_lo[set_size] = lo;
            set_hi[set_size] = hi;
            set_size++;
        end
        else
            set_dropped = 1'b1;
        if (!t.is_last)
            return;
        // insertion sort by start
        for (int i = 1; i < set_size; i++)
        begin
            ks = set_lo[i];
            ke = set_hi[i];
            j  = i;
            while (j > 0 && set_lo[j-1] > ks)
            begin
                set_lo[j] = set_lo[j-1];
                set_hi[j] = set_hi[j-1];
                j--;
            end
            set_lo[j] = ks;
            set_hi[j] = ke;
        end
        // merge walk
        merged  = 0;
        covered = 0;
        cur_lo  = '0;
        cur_hi  = '0;
        for (int i = 0; i < set_size; i++)
        begin
            if (merged != 0 && set_lo[i] <= cur_hi)
            begin
                if (set_hi[i] > cur_hi)
                    cur_hi = set_hi[i];
            end
            else
            begin
                if (merged != 0)
                    covered += longint'(cur_hi) - longint'(cur_lo) + 1;
                cur_lo = set_lo[i];
                cur_hi = set_hi[i];
                merged++;
            end
        end
        if (merged != 0)
            covered += longint'(cur_hi) - longint'(cur_lo) + 1;
        res.covered_bases = (covered > 64'h1FFFFF) ? 21'h1FFFFF : covered[20:0];
        res.merged_count  = (merged > 511) ? 9'h1FF : merged[8:0];
        res.overflow      = set_dropped;
        coverage_queue = {coverage_queue, res};
        set_size    = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic iuc_in_t make_interval(logic [19:0] a, logic [19:0] b, logic last);
        iuc_in_t t;
        t.start_pos = a;
        t.end_pos   = b;
        t.is_last   = last;
        return t;
    endfunction

    // random coordinate: mostly clustered so intervals overlap, some full range
    function automatic logic [19:0] rand_coord(int base);
        if ($urandom_range(0, 3) == 0)
            return 20'($urandom);
        return 20'(base + $urandom_range(0, 200));
    endfunction

    // one set of n intervals with random content
    task automatic add_set(int n);
        int base;
        logic [19:0] a;
        base = $urandom_range(0, 1048575 - 300);
        for (int i = 0; i < n; i++)
        begin
            a = rand_coord(base);
            if ($urandom_range(0, 2) == 0)
                add_interval(make_interval(a, rand_coord(base), i == n - 1));
            else
                add_interval(make_interval(a,
                    20'(a + $urandom_range(0, 40)), i == n - 1));
        end
    endtask

    // stimulus
    initial
    begin
        int total;
        int n;
        // directed: extremes, reversed, touching, disjoint, single points
        add_interval(make_interval(20'h00000, 20'hFFFFF, 1'b1));
        add_interval(make_interval(20'hFFFFF, 20'h00000, 1'b1));
        add_interval(make_interval(20'h00005, 20'h00005, 1'b1));
        add_interval(make_interval(20'd1, 20'd3, 1'b0));
        add_interval(make_interval(20'd4, 20'd5, 1'b1));
        add_interval(make_interval(20'd10, 20'd20, 1'b0));
        add_interval(make_interval(20'd2, 20'd12, 1'b0));
        add_interval(make_interval(20'd30, 20'd25, 1'b0));
        add_interval(make_interval(20'd20, 20'd20, 1'b1));
        add_interval(make_interval(20'hFFFFF, 20'hFFFFF, 1'b0));
        add_interval(make_interval(20'h00000, 20'h00000, 1'b0));
        add_interval(make_interval(20'h55555, 20'hAAAAA, 1'b1));
        add_interval(make_interval(20'h12345, 20'h12300, 1'b0));
        add_interval(make_interval(20'h12345, 20'h12400, 1'b1));
        // store full: 258 intervals, the last dropped one closes the set
        for (int i = 0; i < CAPACITY + 2; i++)
            add_interval(make_interval(20'(i * 3), 20'(i * 3 + 1),
                i == CAPACITY + 1));
        // full set without drop
        add_set(CAPACITY);
        // random sets, mostly small
        total = interval_queue.size();
        while (total < 1550)
        begin
            n = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 260)
                                             : $urandom_range(1, 12);
            add_set(n);
            total += n;
        end
        stim_done = 1'b1;
    end

    // reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (!(stim_done && interval_queue.size() == 0 && !in_valid
                 && coverage_queue.size() == 0))
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (mismatches == 0 && coverage_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        mismatches  = 0;
        quiet_phase = 1'b0;
        in_gap      = 0;
        out_gap     = 0;
        cycles      = 0;
        set_size    = 0;
        set_dropped = 1'b0;
    end

    // driver: transaction accepted at posedge if valid and not stalled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            quiet_phase <= stim_done && interval_queue.size() < 150;
            if (in_valid && !in_done)
            begin
                // hold payload while stalled
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 8);
            end
            else if (interval_queue.size() > 0)
            begin
                in_data  <= interval_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
            // output stall bursts
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= $urandom_range(0, 8);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // input acceptance feeds the model
    always @(posedge clk)
    begin
        in_done <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            model_interval(in_data);
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        iuc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (coverage_queue.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result: covered=%0d merged=%0d overflow=%0b",
                        out_data.covered_bases, out_data.merged_count, out_data.overflow);
            end
            else
            begin
                want = coverage_queue.pop_front();
                if (out_data.covered_bases !== want.covered_bases
                    || out_data.merged_count !== want.merged_count
                    || out_data.overflow !== want.overflow)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: covered %0d/%0d merged %0d/%0d overflow %0b/%0b",
                            want.covered_bases, out_data.covered_bases,
                            want.merged_count, out_data.merged_count,
                            want.overflow, out_data.overflow);
                end
            end
        end
    end

endmodule
